// ----- design/mwm_pkg.sv -----
// shared types and constants for the mecanum wheel mixer
package mwm_pkg;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 15;
  localparam int CMD_W       = 16;
  localparam int DUTY_W      = 16;
  localparam int DUTY_ONE_LG = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_LIN_FS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_FS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RST_LIN_FS    = 15'd256;
  localparam logic [CFG_DATA_W-1:0] RST_ANG_FS    = 15'd512;
  localparam logic [CFG_DATA_W-1:0] RST_SLEW_STEP = 15'd819;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic       store;
    logic       div_start;
    logic       duty_phase;
    logic [1:0] idx;
    logic       tgt_load;
    logic       slew;
    logic       mix;
    logic       peak;
    logic       duty_load;
    logic       out_load;
  } mwm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
  } mwm_stat_t;

endpackage

// ----- design/mwm_in_if.sv -----
// input request channel
interface mwm_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] cmd_vx;
  logic [15:0] cmd_vy;
  logic [15:0] cmd_wz;
  modport source (output valid, cmd, cmd_vx, cmd_vy, cmd_wz, input ready);
  modport sink (input valid, cmd, cmd_vx, cmd_vy, cmd_wz, output ready);
endinterface

// ----- design/mwm_out_if.sv -----
// result request channel
interface mwm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty_front_left;
  logic [15:0] duty_front_right;
  logic [15:0] duty_rear_left;
  logic [15:0] duty_rear_right;
  modport source (output valid, duty_front_left, duty_front_right, duty_rear_left,
                  duty_rear_right, input ready);
  modport sink (input valid, duty_front_left, duty_front_right, duty_rear_left,
                duty_rear_right, output ready);
endinterface

// ----- design/mwm_cfg_if.sv -----
// configuration write channel
interface mwm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [14:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/mwm_div.sv -----
// serial restoring divider, one quotient bit per cycle
module mwm_div #(
  parameter int NW  = 33,
  parameter int DVW = 19
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [NW-1:0]  num,
  input  logic [DVW-1:0] den,
  output logic [NW-1:0]  quo,
  output logic           done
);
  localparam int CW = $clog2(NW);

  logic           busy;
  logic [CW-1:0]  cnt;
  logic [DVW-1:0] rem;
  logic [DVW-1:0] dsr;
  logic [DVW:0]   trial;
  logic           fits;

  assign trial = {rem, quo[NW-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= den;
      quo <= num;
    end else if (busy) begin
      rem <= fits ? DVW'(trial - {1'b0, dsr}) : trial[DVW-1:0];
      quo <= {quo[NW-2:0], fits};
    end
  end
endmodule

// ----- design/mwm_ctrl.sv -----
// sequencer for targets, slew, mix, scaling and result hand-off
module mwm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_cmd,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  input  mwm_pkg::mwm_stat_t stat,
  output mwm_pkg::mwm_cmd_t  ctl
);
  import mwm_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_TGT       = 9'b000000010,
    S_TGT_WAIT  = 9'b000000100,
    S_SLEW      = 9'b000001000,
    S_MIX       = 9'b000010000,
    S_PEAK      = 9'b000100000,
    S_DUTY      = 9'b001000000,
    S_DUTY_WAIT = 9'b010000000,
    S_OUT       = 9'b100000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] idx, idx_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    ctl        = '0;
    ctl.idx    = idx;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_TICK) begin
            state_next = S_TGT;
            idx_next   = 2'd0;
          end else begin
            ctl.store = 1'b1;
          end
        end
      end
      S_TGT: begin
        ctl.div_start = 1'b1;
        state_next    = S_TGT_WAIT;
      end
      S_TGT_WAIT: begin
        if (stat.div_done) begin
          ctl.tgt_load = 1'b1;
          if (idx == 2'd2) begin
            state_next = S_SLEW;
          end else begin
            idx_next   = idx + 2'd1;
            state_next = S_TGT;
          end
        end
      end
      S_SLEW: begin
        ctl.slew   = 1'b1;
        state_next = S_MIX;
      end
      S_MIX: begin
        ctl.mix    = 1'b1;
        state_next = S_PEAK;
      end
      S_PEAK: begin
        ctl.peak   = 1'b1;
        idx_next   = 2'd0;
        state_next = S_DUTY;
      end
      S_DUTY: begin
        ctl.div_start  = 1'b1;
        ctl.duty_phase = 1'b1;
        state_next     = S_DUTY_WAIT;
      end
      S_DUTY_WAIT: begin
        ctl.duty_phase = 1'b1;
        if (stat.div_done) begin
          ctl.duty_load = 1'b1;
          if (idx == 2'd3) begin
            state_next = S_OUT;
          end else begin
            idx_next   = idx + 2'd1;
            state_next = S_DUTY;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// ----- design/mwm_dp.sv -----
// datapath: config, stored commands, ramps, wheel sums, scaling divider
module mwm_dp #(
  parameter int NORM_FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mwm_pkg::mwm_cmd_t           ctl,
  output mwm_pkg::mwm_stat_t          stat,
  input  logic                        cfg_we,
  input  logic [mwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mwm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [mwm_pkg::CMD_W-1:0]   in_vx,
  input  logic [mwm_pkg::CMD_W-1:0]   in_vy,
  input  logic [mwm_pkg::CMD_W-1:0]   in_wz,
  output logic [mwm_pkg::DUTY_W-1:0]  out_fl,
  output logic [mwm_pkg::DUTY_W-1:0]  out_fr,
  output logic [mwm_pkg::DUTY_W-1:0]  out_rl,
  output logic [mwm_pkg::DUTY_W-1:0]  out_rr
);
  import mwm_pkg::*;

  localparam int F   = NORM_FRAC_BITS;
  localparam int RW  = F + 4;
  localparam int SW  = F + 6;
  localparam int PW  = F + 5;
  localparam int NW  = F + 19;
  localparam int DVW = (F + 5 > CFG_DATA_W) ? F + 5 : CFG_DATA_W;
  localparam int LW  = CFG_DATA_W + F;

  localparam logic signed [RW-1:0] NORM_MAX = {1'b0, {(RW-1){1'b1}}};
  localparam logic signed [RW-1:0] NORM_MIN = {1'b1, {(RW-1){1'b0}}};
  localparam logic [NW-1:0] MAG_MAX = NW'({1'b0, {(RW-1){1'b1}}});
  localparam logic [PW-1:0] PEAK_ONE = PW'(1) << F;

  logic [CFG_DATA_W-1:0] lin_full_scale, ang_full_scale, slew_step;
  logic signed [CMD_W-1:0] stored [3];
  logic signed [RW-1:0]    ramped [3];
  logic signed [RW-1:0]    target [3];
  logic signed [SW-1:0]    sums [4];
  logic [PW-1:0]           peak;
  logic [DUTY_W-1:0]       duty [4];

  // divider operands
  logic signed [CMD_W-1:0] sel_cmd;
  logic [CMD_W-1:0]        cmd_mag;
  logic [CFG_DATA_W-1:0]   sel_fs;
  logic signed [SW-1:0]    sel_sum;
  logic [SW-1:0]           sum_mag;
  logic [NW-1:0]           num;
  logic [DVW-1:0]          den;
  logic [NW-1:0]           quo;
  logic signed [RW-1:0]    tgt_val;
  logic [DUTY_W-1:0]       q_duty;

  assign sel_cmd = stored[ctl.idx];
  assign cmd_mag = sel_cmd[CMD_W-1] ? CMD_W'(-sel_cmd) : sel_cmd;
  assign sel_fs  = (ctl.idx == 2'd2) ? ang_full_scale : lin_full_scale;
  assign sel_sum = sums[ctl.idx];
  assign sum_mag = sel_sum[SW-1] ? SW'(-sel_sum) : sel_sum;

  always_comb begin
    if (ctl.duty_phase) begin
      num = NW'(sum_mag) << DUTY_ONE_LG;
      den = DVW'(peak);
    end else begin
      num = NW'(cmd_mag) << F;
      den = DVW'(sel_fs);
    end
  end

  mwm_div #(.NW(NW), .DVW(DVW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.div_start),
    .num   (num),
    .den   (den),
    .quo   (quo),
    .done  (stat.div_done)
  );

  // target: saturated quotient, zero full scale handled apart
  always_comb begin
    if (sel_fs == '0) begin
      if (sel_cmd == '0)          tgt_val = '0;
      else if (sel_cmd[CMD_W-1])  tgt_val = NORM_MIN;
      else                        tgt_val = NORM_MAX;
    end else if (sel_cmd[CMD_W-1]) begin
      tgt_val = (quo > MAG_MAX) ? NORM_MIN : RW'(-quo);
    end else begin
      tgt_val = (quo > MAG_MAX) ? NORM_MAX : RW'(quo);
    end
  end

  assign q_duty = sel_sum[SW-1] ? DUTY_W'(-quo) : DUTY_W'(quo);

  // slew limit rescaled to the normalized fraction
  logic [LW-1:0]        lim_full;
  logic signed [RW:0]   lim;
  logic signed [RW:0]   diff [3];
  logic signed [RW:0]   step [3];
  assign lim_full = ({slew_step, F'(0)}) >> DUTY_ONE_LG;
  assign lim      = (RW+1)'(lim_full);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = (RW+1)'(target[i]) - (RW+1)'(ramped[i]);
      if (diff[i] > lim)       step[i] = lim;
      else if (diff[i] < -lim) step[i] = -lim;
      else                     step[i] = diff[i];
    end
  end

  // peak of the four sum magnitudes, floor of 1.0
  logic [PW-1:0] mags [4];
  logic [PW-1:0] pk_a, pk_b, pk_c;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mags[i] = sums[i][SW-1] ? PW'(-sums[i]) : PW'(sums[i]);
    end
    pk_a = (mags[0] > mags[1]) ? mags[0] : mags[1];
    pk_b = (mags[2] > mags[3]) ? mags[2] : mags[3];
    pk_c = (pk_a > pk_b) ? pk_a : pk_b;
  end

  logic signed [SW-1:0] rx, ry, rz;
  assign rx = SW'(ramped[0]);
  assign ry = SW'(ramped[1]);
  assign rz = SW'(ramped[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      lin_full_scale <= RST_LIN_FS;
      ang_full_scale <= RST_ANG_FS;
      slew_step      <= RST_SLEW_STEP;
      for (int i = 0; i < 3; i++) begin
        stored[i] <= '0;
        ramped[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LIN_FS:    lin_full_scale <= cfg_data;
          CFG_ANG_FS:    ang_full_scale <= cfg_data;
          CFG_SLEW_STEP: slew_step      <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.store) begin
        stored[0] <= in_vx;
        stored[1] <= in_vy;
        stored[2] <= in_wz;
      end
      if (ctl.slew) begin
        for (int i = 0; i < 3; i++) begin
          ramped[i] <= RW'((RW+1)'(ramped[i]) + step[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tgt_load) target[ctl.idx] <= tgt_val;
    if (ctl.mix) begin
      sums[0] <= rx - ry - rz;
      sums[1] <= rx + ry + rz;
      sums[2] <= rx + ry - rz;
      sums[3] <= rx - ry + rz;
    end
    if (ctl.peak) peak <= (pk_c > PEAK_ONE) ? pk_c : PEAK_ONE;
    if (ctl.duty_load) duty[ctl.idx] <= q_duty;
    if (ctl.out_load) begin
      out_fl <= duty[0];
      out_fr <= duty[1];
      out_rl <= duty[2];
      out_rr <= duty[3];
    end
  end
endmodule

// ----- design/mecanum_wheel_mixer_with_slew.sv -----
// top level of the mecanum wheel mixer with command slew limiting
//
//  channel  dir  handshake          payload
//  in_ch    in   valid / ready      cmd, cmd_vx, cmd_vy, cmd_wz
//  out_ch   out  valid / ready      duty_front_left/right, duty_rear_left/right
//  cfg_ch   in   valid / ready=1    index (0 linear full scale, 1 turn full scale,
//                                   2 slew step), data
//
//  a store request gives no result
//  a tick request runs 7 serial divisions (start, quotient bits, done) then slew, mix,
//  peak and output load; no new request is taken until the tick has finished
//  synchronous active-high rst restores register defaults and clears all commands
//  the finished result sits in an output register; a new request is taken while it waits
//  a tick whose result finds that register still full holds until it drains
module mecanum_wheel_mixer_with_slew #(
  parameter int NORM_FRAC_BITS = 14
) (
  input logic        clk,
  input logic        rst,
  mwm_in_if.sink     in_ch,
  mwm_out_if.source  out_ch,
  mwm_cfg_if.sink    cfg_ch
);
  import mwm_pkg::*;

  mwm_cmd_t  ctl;
  mwm_stat_t stat;

  // configuration is always taken
  assign cfg_ch.ready = 1'b1;

  // sequencer
  mwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .ctl       (ctl)
  );

  // arithmetic and state
  mwm_dp #(.NORM_FRAC_BITS(NORM_FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .in_vx     (in_ch.cmd_vx),
    .in_vy     (in_ch.cmd_vy),
    .in_wz     (in_ch.cmd_wz),
    .out_fl    (out_ch.duty_front_left),
    .out_fr    (out_ch.duty_front_right),
    .out_rl    (out_ch.duty_rear_left),
    .out_rr    (out_ch.duty_rear_right)
  );
endmodule
